// ===== hdl/gpc_pkg.sv =====
`default_nettype none

package gpc_pkg;

  localparam int DIM_WIDTH   = 8;
  localparam int PATHS_WIDTH = 32;

  typedef struct packed {
    logic [DIM_WIDTH-1:0] rows;
    logic [DIM_WIDTH-1:0] cols;
  } gpc_in_t;

  typedef struct packed {
    logic [PATHS_WIDTH-1:0] paths;
    logic                   saturated;
  } gpc_out_t;

  typedef struct packed {
    logic start;
    logic step;
    logic load_out;
  } gpc_cmd_t;

  typedef struct packed {
    logic empty;
    logic last_cell;
  } gpc_status_t;

endpackage

`default_nettype wire

// ===== hdl/gpc_ram.sv =====
`default_nettype none

module gpc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== hdl/gpc_ctrl.sv =====
`default_nettype none

module gpc_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  input  wire gpc_pkg::gpc_status_t status,
  output gpc_pkg::gpc_cmd_t         cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FINISH
  } state_t;

  state_t state_r;
  logic   out_valid_r;

  assign in_ready     = (state_r == ST_IDLE);
  assign out_valid    = out_valid_r;
  assign cmd.start    = in_valid && (state_r == ST_IDLE);
  assign cmd.step     = (state_r == ST_RUN);
  assign cmd.load_out = (state_r == ST_FINISH) && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (cmd.start) begin
            state_r <= status.empty ? ST_FINISH : ST_RUN;
          end
        end
        ST_RUN: begin
          if (status.last_cell) begin
            state_r <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (cmd.load_out) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase

      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/gpc_dpath.sv =====
`default_nettype none

module gpc_dpath #(
  parameter int MAX_DIM     = 128,
  parameter int COUNT_WIDTH = 32
) (
  input  wire logic              clk,
  input  wire gpc_pkg::gpc_in_t  in_data,
  input  wire gpc_pkg::gpc_cmd_t cmd,
  output gpc_pkg::gpc_status_t   status,
  output gpc_pkg::gpc_out_t      out_data
);

  localparam int IDXW = $clog2(MAX_DIM);
  localparam int DIMW = $clog2(MAX_DIM + 1);
  localparam int CMPW = (DIMW > gpc_pkg::DIM_WIDTH) ? DIMW : gpc_pkg::DIM_WIDTH;
  localparam logic [COUNT_WIDTH-1:0] COUNT_LIMIT = {COUNT_WIDTH{1'b1}};

  logic [CMPW-1:0]        rows_ext;
  logic [CMPW-1:0]        cols_ext;
  logic [CMPW-1:0]        rows_cl;
  logic [CMPW-1:0]        cols_cl;
  logic [IDXW-1:0]        row_r;
  logic [IDXW-1:0]        col_r;
  logic [IDXW-1:0]        last_row_r;
  logic [IDXW-1:0]        last_col_r;
  logic [IDXW-1:0]        col_next;
  logic [COUNT_WIDTH-1:0] left_r;
  logic [COUNT_WIDTH-1:0] result_r;
  logic [COUNT_WIDTH-1:0] above;
  logic [COUNT_WIDTH-1:0] left;
  logic [COUNT_WIDTH-1:0] ram_rdata;
  logic [COUNT_WIDTH:0]   sum;
  logic [COUNT_WIDTH-1:0] cell_value;
  logic                   col_last;
  gpc_pkg::gpc_out_t      out_r;

  assign rows_ext = CMPW'(in_data.rows);
  assign cols_ext = CMPW'(in_data.cols);
  assign rows_cl  = (rows_ext > CMPW'(MAX_DIM)) ? CMPW'(MAX_DIM) : rows_ext;
  assign cols_cl  = (cols_ext > CMPW'(MAX_DIM)) ? CMPW'(MAX_DIM) : cols_ext;

  assign status.empty     = (in_data.rows == '0) || (in_data.cols == '0);
  assign col_last         = (col_r == last_col_r);
  assign status.last_cell = col_last && (row_r == last_row_r);
  assign col_next         = col_last ? '0 : col_r + IDXW'(1);

  // Column zero always holds one, so memory is read only for inner columns,
  // and each such read is taken after the matching write has landed.
  always_comb begin
    if (row_r == '0) begin
      above = '0;
    end else if (col_r == '0) begin
      above = COUNT_WIDTH'(1);
    end else begin
      above = ram_rdata;
    end
    left = (col_r == '0) ? '0 : left_r;
    sum  = {1'b0, above} + {1'b0, left};
    if ((row_r == '0) && (col_r == '0)) begin
      cell_value = COUNT_WIDTH'(1);
    end else if (sum[COUNT_WIDTH]) begin
      cell_value = COUNT_LIMIT;
    end else begin
      cell_value = sum[COUNT_WIDTH-1:0];
    end
  end

  gpc_ram #(
    .WIDTH(COUNT_WIDTH),
    .DEPTH(MAX_DIM)
  ) u_row_ram (
    .clk  (clk),
    .we   (cmd.step),
    .waddr(col_r),
    .wdata(cell_value),
    .raddr(col_next),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      row_r      <= '0;
      col_r      <= '0;
      last_row_r <= IDXW'(rows_cl - CMPW'(1));
      last_col_r <= IDXW'(cols_cl - CMPW'(1));
      result_r   <= '0;
    end else if (cmd.step) begin
      left_r <= cell_value;
      col_r  <= col_next;
      if (col_last) begin
        row_r <= row_r + IDXW'(1);
      end
      if (status.last_cell) begin
        result_r <= cell_value;
      end
    end
    if (cmd.load_out) begin
      out_r.paths     <= gpc_pkg::PATHS_WIDTH'(result_r);
      out_r.saturated <= (result_r == COUNT_LIMIT);
    end
  end

  assign out_data = out_r;

endmodule

`default_nettype wire

// ===== hdl/grid_path_counter.sv =====
`default_nettype none

// Counts the monotone right/down paths across a grid of rows by cols cells.
// The input channel (in_valid, in_ready, in_data) carries one grid size per
// transfer; dimensions above MAX_DIM are clamped to MAX_DIM, and a zero
// dimension gives a count of zero. The result channel (out_valid, out_ready,
// out_data) carries one count per input, with saturated set when the count
// reached 2^COUNT_WIDTH - 1.
// One item is worked at a time. A shared saturating adder visits one grid
// cell per cycle over a single row buffer memory, so out_valid rises once
// the last cell is done and the output register is free (an empty grid skips
// the cell walk), and the next input is taken in the cycle after the result
// is loaded.
// The result sits in an output register, so a new item is accepted while the
// previous result still waits for out_ready. If the receiver stalls longer
// than the next item takes, that item holds its result until the output
// register frees up. Reset (rst_n low, synchronous) returns the block to
// idle and drops out_valid; the row buffer needs no clearing.
module grid_path_counter #(
  parameter int MAX_DIM     = 128,
  parameter int COUNT_WIDTH = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire gpc_pkg::gpc_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output gpc_pkg::gpc_out_t      out_data
);

  gpc_pkg::gpc_cmd_t    cmd;
  gpc_pkg::gpc_status_t status;

  gpc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status   (status),
    .cmd      (cmd)
  );

  gpc_dpath #(
    .MAX_DIM    (MAX_DIM),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_dpath (
    .clk     (clk),
    .in_data (in_data),
    .cmd     (cmd),
    .status  (status),
    .out_data(out_data)
  );

endmodule

`default_nettype wire

// ===== hdl/gpc_checker.sv =====
`default_nettype none

module gpc_checker #(
  parameter int COUNT_WIDTH = 32
) (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire gpc_pkg::gpc_out_t out_data
);

  localparam logic [gpc_pkg::PATHS_WIDTH-1:0] PATHS_LIMIT =
    gpc_pkg::PATHS_WIDTH'({COUNT_WIDTH{1'b1}});

  // A stalled result must hold until its transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  // The block works one item at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in progress");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.saturated |-> out_data.paths == PATHS_LIMIT)
    else $error("saturated flag without the saturation value");

  a_empty_no_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.paths == '0) |-> !out_data.saturated)
    else $error("zero count flagged as saturated");

endmodule

bind grid_path_counter gpc_checker #(
  .COUNT_WIDTH(COUNT_WIDTH)
) u_gpc_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);

`default_nettype wire
